### rtl/core/lcd_pkg.sv
// Shared types and constants for the lamp command decoder.
// No dependencies; every module of the decoder imports this package.
package lcd_pkg;

    localparam int MSG_DEPTH = 5;
    localparam int POS_W     = 3;
    localparam int QDEPTH    = 2;
    localparam int QAW       = $clog2(QDEPTH);
    localparam int QCW       = $clog2(QDEPTH + 1);

    localparam logic [7:0]  END_BYTE       = 8'h0A;
    localparam logic [7:0]  CH_COLOR       = 8'h63;  // 'c'
    localparam logic [7:0]  CH_INTERVAL    = 8'h69;  // 'i'
    localparam logic [7:0]  CH_RAND_SET    = 8'h52;  // 'R'
    localparam logic [7:0]  CH_RAND_CLR    = 8'h72;  // 'r'
    localparam logic [7:0]  CH_LIGHT_SET   = 8'h4C;  // 'L'
    localparam logic [7:0]  CH_LIGHT_CLR   = 8'h6C;  // 'l'
    localparam logic [7:0]  CH_PUMP_SET    = 8'h50;  // 'P'
    localparam logic [7:0]  CH_PUMP_CLR    = 8'h70;  // 'p'
    localparam logic [7:0]  CH_WAVE_FIRST  = 8'h31;  // '1'
    localparam logic [7:0]  CH_WAVE_LAST   = 8'h35;  // '5'

    localparam logic [7:0]  LEVEL_RESET    = 8'hFF;
    localparam logic [31:0] INTERVAL_RESET = 32'd1500;
    localparam logic [15:0] ROUND_HALF     = 16'd127;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_COLOR,
        OP_INTERVAL,
        OP_RAND_SET,
        OP_RAND_CLR,
        OP_LIGHT_SET,
        OP_LIGHT_CLR,
        OP_PUMP_SET,
        OP_PUMP_CLR,
        OP_WAVE
    } op_t;

    typedef struct packed {
        op_t             op;
        logic [2:0]      wave;
        logic [3:0][7:0] arg;   // message bytes 1..4, arg[0] is byte 1
        logic            done;
    } cmd_t;

    typedef enum logic {
        BK_RUN,
        BK_SCALE
    } bk_state_t;

    // floor(x / 255) for x below 65280
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
        return s[15:8];
    endfunction

endpackage

### rtl/core/lcd_front.sv
// Front part: collects message bytes and classifies a finished message.
// Depends on lcd_pkg; pushes one cmd_t per accepted byte into lcd_queue.
module lcd_front
    import lcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] rx_byte,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_entry
);

    logic [7:0]       msg_reg  [MSG_DEPTH];
    logic [7:0]       msg_view [MSG_DEPTH];
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             accept;
    logic             is_end;
    logic             pos_open;
    logic [7:0]       code;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign q_push   = accept;
    assign is_end   = (rx_byte == END_BYTE);
    assign pos_open = (pos_reg < POS_W'(MSG_DEPTH));

    // message as it stands once this byte is stored
    always_comb
    begin
        for (int i = 0; i < MSG_DEPTH; i++)
        begin
            msg_view[i] = (pos_open && pos_reg == POS_W'(i)) ? rx_byte : msg_reg[i];
        end
    end

    assign code = msg_view[0];

    always_comb
    begin
        q_entry.arg  = {msg_view[4], msg_view[3], msg_view[2], msg_view[1]};
        q_entry.done = is_end;
        q_entry.wave = 3'(code - CH_WAVE_FIRST);
        q_entry.op   = OP_NONE;
        if (is_end)
        begin
            case (code)
                CH_COLOR:     q_entry.op = OP_COLOR;
                CH_INTERVAL:  q_entry.op = OP_INTERVAL;
                CH_RAND_SET:  q_entry.op = OP_RAND_SET;
                CH_RAND_CLR:  q_entry.op = OP_RAND_CLR;
                CH_LIGHT_SET: q_entry.op = OP_LIGHT_SET;
                CH_LIGHT_CLR: q_entry.op = OP_LIGHT_CLR;
                CH_PUMP_SET:  q_entry.op = OP_PUMP_SET;
                CH_PUMP_CLR:  q_entry.op = OP_PUMP_CLR;
                default:
                begin
                    if (code >= CH_WAVE_FIRST && code <= CH_WAVE_LAST)
                    begin
                        q_entry.op = OP_WAVE;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (is_end)
        begin
            pos_next = '0;
        end
        else if (pos_open)
        begin
            pos_next = pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            for (int i = 0; i < MSG_DEPTH; i++)
            begin
                msg_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
            for (int i = 0; i < MSG_DEPTH; i++)
            begin
                msg_reg[i] <= msg_view[i];
            end
        end
    end

endmodule

### rtl/core/lcd_queue.sv
// Short command queue between the front and back parts.
// Depends on lcd_pkg for cmd_t and the queue depth.
module lcd_queue
    import lcd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_entry,
    input  logic pop,
    output cmd_t head,
    output logic empty,
    output logic full
);

    cmd_t           entry_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QCW-1:0] count_reg;
    logic [QCW-1:0] count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == QCW'(QDEPTH));
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### rtl/core/lcd_back.sv
// Back part: executes queued commands, holds the lamp settings and the result slot.
// Depends on lcd_pkg; reads commands from lcd_queue.
module lcd_back
    import lcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        head,
    input  logic        q_empty,
    output logic        q_pop,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out,
    output logic [7:0]  alpha_out,
    output logic        light_on,
    output logic        pump_on,
    output logic [7:0]  pump_drive,
    output logic        random_on,
    output logic [2:0]  wave_out,
    output logic [31:0] interval_ms,
    output logic        periodic_on,
    output logic        message_done,
    output logic        out_valid,
    input  logic        out_ready
);

    bk_state_t        state_reg;
    bk_state_t        state_next;
    logic [7:0]       red_reg,   red_next;
    logic [7:0]       green_reg, green_next;
    logic [7:0]       blue_reg,  blue_next;
    logic [7:0]       alpha_reg, alpha_next;
    logic             light_reg, light_next;
    logic             pump_reg,  pump_next;
    logic             random_reg, random_next;
    logic [2:0]       wave_reg,  wave_next;
    logic [31:0]      interval_reg, interval_next;
    logic             done_reg,  done_next;
    logic             valid_reg, valid_next;
    logic [2:0][15:0] prod_reg,  prod_next;
    logic             slot_free;
    logic             load;

    assign slot_free = !valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_RUN:
            begin
                if (slot_free && !q_empty && head.op == OP_COLOR)
                begin
                    state_next = BK_SCALE;
                end
            end
            BK_SCALE:
            begin
                if (slot_free)
                begin
                    state_next = BK_RUN;
                end
            end
            default: state_next = BK_RUN;
        endcase
    end

    always_comb
    begin
        red_next      = red_reg;
        green_next    = green_reg;
        blue_next     = blue_reg;
        alpha_next    = alpha_reg;
        light_next    = light_reg;
        pump_next     = pump_reg;
        random_next   = random_reg;
        wave_next     = wave_reg;
        interval_next = interval_reg;
        done_next     = done_reg;
        prod_next     = prod_reg;
        q_pop         = 1'b0;
        load          = 1'b0;
        case (state_reg)
            BK_RUN:
            begin
                if (slot_free && !q_empty)
                begin
                    q_pop     = 1'b1;
                    load      = (head.op != OP_COLOR);
                    done_next = head.done;
                    case (head.op)
                        OP_COLOR:
                        begin
                            random_next = 1'b0;
                            if (head.arg[3] != END_BYTE)
                            begin
                                alpha_next = head.arg[3];
                            end
                            for (int i = 0; i < 3; i++)
                            begin
                                prod_next[i] = {8'b0, head.arg[i]} * {8'b0, alpha_next}
                                             + ROUND_HALF;
                            end
                        end
                        OP_INTERVAL:  interval_next = head.arg;
                        OP_RAND_SET:  random_next = 1'b1;
                        OP_RAND_CLR:  random_next = 1'b0;
                        OP_LIGHT_SET: light_next = 1'b1;
                        OP_LIGHT_CLR: light_next = 1'b0;
                        OP_PUMP_SET:  pump_next = 1'b1;
                        OP_PUMP_CLR:  pump_next = 1'b0;
                        OP_WAVE:      wave_next = head.wave;
                        default:      ;
                    endcase
                end
            end
            BK_SCALE:
            begin
                if (slot_free)
                begin
                    load       = 1'b1;
                    red_next   = div255(prod_reg[0]);
                    green_next = div255(prod_reg[1]);
                    blue_next  = div255(prod_reg[2]);
                end
            end
            default: ;
        endcase
        valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_RUN;
            red_reg      <= LEVEL_RESET;
            green_reg    <= LEVEL_RESET;
            blue_reg     <= LEVEL_RESET;
            alpha_reg    <= LEVEL_RESET;
            light_reg    <= 1'b1;
            pump_reg     <= 1'b0;
            random_reg   <= 1'b0;
            wave_reg     <= '0;
            interval_reg <= INTERVAL_RESET;
            done_reg     <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            red_reg      <= red_next;
            green_reg    <= green_next;
            blue_reg     <= blue_next;
            alpha_reg    <= alpha_next;
            light_reg    <= light_next;
            pump_reg     <= pump_next;
            random_reg   <= random_next;
            wave_reg     <= wave_next;
            interval_reg <= interval_next;
            done_reg     <= done_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // settings only change when the slot is empty or being taken
    assign red_out      = red_reg;
    assign green_out    = green_reg;
    assign blue_out     = blue_reg;
    assign alpha_out    = alpha_reg;
    assign light_on     = light_reg;
    assign pump_on      = pump_reg;
    assign pump_drive   = pump_reg ? alpha_reg : 8'd0;
    assign random_on    = random_reg;
    assign wave_out     = wave_reg;
    assign interval_ms  = interval_reg;
    assign periodic_on  = (interval_reg != '0);
    assign message_done = done_reg;
    assign out_valid    = valid_reg;

endmodule

### rtl/core/lamp_command_decoder_unit.sv
// Lamp command decoder top level: front, command queue and back.
// Depends on lcd_pkg, lcd_front, lcd_queue and lcd_back.

// One received byte goes in per item and one result with the full lamp
// settings comes out per item. The front stores bytes 0 to 4 of a message
// and can take a byte every cycle while the two-entry queue has room. The
// back executes one queued item per cycle while its result slot is free or
// being taken. The newline of a colour command goes through BK_RUN, which
// forms the three 8x8 alpha products, and then BK_SCALE, which does the
// divide by 255. The result register lets the back take the next item in
// the cycle its current result is taken.
module lamp_command_decoder_unit
    import lcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  rx_byte,
    input  logic        in_valid,
    output logic        in_ready,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out,
    output logic [7:0]  alpha_out,
    output logic        light_on,
    output logic        pump_on,
    output logic [7:0]  pump_drive,
    output logic        random_on,
    output logic [2:0]  wave_out,
    output logic [31:0] interval_ms,
    output logic        periodic_on,
    output logic        message_done,
    output logic        out_valid,
    input  logic        out_ready
);

    cmd_t push_entry;
    cmd_t head;
    logic push;
    logic pop;
    logic q_empty;
    logic q_full;

    lcd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_byte  (rx_byte),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .q_full   (q_full),
        .q_push   (push),
        .q_entry  (push_entry)
    );

    lcd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty),
        .full       (q_full)
    );

    lcd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_empty      (q_empty),
        .q_pop        (pop),
        .red_out      (red_out),
        .green_out    (green_out),
        .blue_out     (blue_out),
        .alpha_out    (alpha_out),
        .light_on     (light_on),
        .pump_on      (pump_on),
        .pump_drive   (pump_drive),
        .random_on    (random_on),
        .wave_out     (wave_out),
        .interval_ms  (interval_ms),
        .periodic_on  (periodic_on),
        .message_done (message_done),
        .out_valid    (out_valid),
        .out_ready    (out_ready)
    );

endmodule

### bench/lamp_command_decoder_unit_tb.sv
// Self-checking bench for lamp_command_decoder_unit: byte-level messages in, full lamp status out.
// Depends on lcd_pkg and the decoder RTL; predicts every status item and compares field by field.
module lamp_command_decoder_unit_tb
    import lcd_pkg::*;
();

    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_ITEMS  = 250;
    localparam int DRAIN_CYCLES = 20;

    typedef logic [7:0] byte_q_t [$];

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        light;
        logic        pump;
        logic [7:0]  pump_pwm;
        logic        rnd_mode;
        logic [2:0]  wave;
        logic [31:0] interval;
        logic        periodic;
        logic        done;
    } lamp_status_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic [7:0]  rx_byte   = 8'h00;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [7:0]  alpha_out;
    logic        light_on;
    logic        pump_on;
    logic [7:0]  pump_drive;
    logic        random_on;
    logic [2:0]  wave_out;
    logic [31:0] interval_ms;
    logic        periodic_on;
    logic        message_done;
    logic        out_valid;
    logic        out_ready = 1'b0;

    // Lamp state as the decoder should hold it
    logic [7:0]  msg_buf [MSG_DEPTH];
    int          msg_pos;
    logic [7:0]  red_lvl;
    logic [7:0]  green_lvl;
    logic [7:0]  blue_lvl;
    logic [7:0]  alpha_lvl;
    logic        light_en;
    logic        pump_en;
    logic        rnd_en;
    logic [2:0]  wave_sel;
    logic [31:0] interval_val;

    lamp_status_t expected_status_q [$];
    int errors        = 0;
    int items_sent    = 0;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    lamp_command_decoder_unit dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", field, got, want, cycle_count);
        errors++;
    endtask

    function automatic logic [7:0] alpha_scale(input logic [7:0] v, input logic [7:0] a);
        int unsigned p;
        p = int'(v) * int'(a) + 127;
        return 8'(p / 255);
    endfunction

    function void reset_lamp_model();
        foreach (msg_buf[i])
            msg_buf[i] = 8'h00;
        msg_pos      = 0;
        red_lvl      = 8'hFF;
        green_lvl    = 8'hFF;
        blue_lvl     = 8'hFF;
        alpha_lvl    = 8'hFF;
        light_en     = 1'b1;
        pump_en      = 1'b0;
        rnd_en       = 1'b0;
        wave_sel     = 3'd0;
        interval_val = 32'd1500;
    endfunction

    function void run_lamp_command();
        case (msg_buf[0])
            CH_COLOR:
            begin
                rnd_en = 1'b0;
                // a newline in the alpha slot keeps the stored alpha
                if (msg_buf[4] != END_BYTE)
                    alpha_lvl = msg_buf[4];
                red_lvl   = alpha_scale(msg_buf[1], alpha_lvl);
                green_lvl = alpha_scale(msg_buf[2], alpha_lvl);
                blue_lvl  = alpha_scale(msg_buf[3], alpha_lvl);
            end
            CH_INTERVAL:  interval_val = {msg_buf[4], msg_buf[3], msg_buf[2], msg_buf[1]};
            CH_RAND_SET:  rnd_en   = 1'b1;
            CH_RAND_CLR:  rnd_en   = 1'b0;
            CH_LIGHT_SET: light_en = 1'b1;
            CH_LIGHT_CLR: light_en = 1'b0;
            CH_PUMP_SET:  pump_en  = 1'b1;
            CH_PUMP_CLR:  pump_en  = 1'b0;
            default:
            begin
                if (msg_buf[0] >= CH_WAVE_FIRST && msg_buf[0] <= CH_WAVE_LAST)
                    wave_sel = 3'(msg_buf[0] - CH_WAVE_FIRST);
            end
        endcase
    endfunction

    function void predict_lamp_status(input logic [7:0] b);
        lamp_status_t s;
        logic         done;
        done = 1'b0;
        if (msg_pos < MSG_DEPTH)
            msg_buf[msg_pos] = b;
        if (b == END_BYTE)
        begin
            run_lamp_command();
            msg_pos = 0;
            done    = 1'b1;
        end
        else if (msg_pos < MSG_DEPTH)
            msg_pos++;
        s.red      = red_lvl;
        s.green    = green_lvl;
        s.blue     = blue_lvl;
        s.alpha    = alpha_lvl;
        s.light    = light_en;
        s.pump     = pump_en;
        s.pump_pwm = pump_en ? alpha_lvl : 8'h00;
        s.rnd_mode = rnd_en;
        s.wave     = wave_sel;
        s.interval = interval_val;
        s.periodic = (interval_val != 32'd0);
        s.done     = done;
        expected_status_q.push_back(s);
    endfunction

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin : check_status
        lamp_status_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_status_q.size() == 0)
                report_mismatch("item with nothing pending", 32'd0, 32'd0);
            else
            begin
                want = expected_status_q.pop_front();
                if (red_out !== want.red)
                    report_mismatch("red_out", 32'(red_out), 32'(want.red));
                if (green_out !== want.green)
                    report_mismatch("green_out", 32'(green_out), 32'(want.green));
                if (blue_out !== want.blue)
                    report_mismatch("blue_out", 32'(blue_out), 32'(want.blue));
                if (alpha_out !== want.alpha)
                    report_mismatch("alpha_out", 32'(alpha_out), 32'(want.alpha));
                if (light_on !== want.light)
                    report_mismatch("light_on", 32'(light_on), 32'(want.light));
                if (pump_on !== want.pump)
                    report_mismatch("pump_on", 32'(pump_on), 32'(want.pump));
                if (pump_drive !== want.pump_pwm)
                    report_mismatch("pump_drive", 32'(pump_drive), 32'(want.pump_pwm));
                if (random_on !== want.rnd_mode)
                    report_mismatch("random_on", 32'(random_on), 32'(want.rnd_mode));
                if (wave_out !== want.wave)
                    report_mismatch("wave_out", 32'(wave_out), 32'(want.wave));
                if (interval_ms !== want.interval)
                    report_mismatch("interval_ms", interval_ms, want.interval);
                if (periodic_on !== want.periodic)
                    report_mismatch("periodic_on", 32'(periodic_on), 32'(want.periodic));
                if (message_done !== want.done)
                    report_mismatch("message_done", 32'(message_done), 32'(want.done));
            end
        end
    end

    // Present one byte, hold it until accepted, then predict its status item.
    task automatic send_item(input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        predict_lamp_status(b);
        items_sent++;
    endtask

    task automatic send_bytes(input byte_q_t seq);
        foreach (seq[i])
            send_item(seq[i]);
    endtask

    task automatic test_empty_message();
        // first item also shows the reset settings
        send_bytes('{END_BYTE});
    endtask

    task automatic test_color();
        send_bytes('{CH_COLOR, 8'hFF, 8'h00, 8'h80, 8'hFF, END_BYTE});
        // newline in the alpha slot: keep alpha, rescale colors
        send_bytes('{CH_COLOR, 8'h01, 8'hFE, 8'h7F, END_BYTE});
    endtask

    task automatic test_long_interval();
        // bytes past the fifth position are dropped
        send_bytes('{CH_INTERVAL, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h5A, END_BYTE});
    endtask

    task automatic test_flags();
        send_bytes('{CH_PUMP_SET, END_BYTE, CH_RAND_SET, END_BYTE,
                     CH_LIGHT_CLR, END_BYTE, CH_WAVE_LAST, END_BYTE});
    endtask

    task automatic send_random_message();
        byte_q_t    seq;
        int         pick;
        int         n_args;
        logic       zero_args;
        logic [7:0] code;
        logic [7:0] arg;
        if ($urandom_range(0, 99) < 80)
        begin
            pick = $urandom_range(0, 15);
            case (pick)
                0:       code = CH_COLOR;
                1:       code = CH_INTERVAL;
                2:       code = CH_RAND_SET;
                3:       code = CH_RAND_CLR;
                4:       code = CH_LIGHT_SET;
                5:       code = CH_LIGHT_CLR;
                6:       code = CH_PUMP_SET;
                7:       code = CH_PUMP_CLR;
                15:      code = 8'($urandom_range(0, 255));
                default: code = CH_WAVE_FIRST + 8'(pick - 8) % 8'd5;
            endcase
            if (code == CH_COLOR)
                n_args = $urandom_range(3, 4);
            else if (code == CH_INTERVAL)
                n_args = 4;
            else
                n_args = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : 0;
            zero_args = (code == CH_INTERVAL) && ($urandom_range(0, 7) == 0);
            seq.push_back(code);
            for (int i = 0; i < n_args; i++)
            begin
                case ($urandom_range(0, 5))
                    0:       arg = 8'h00;
                    1:       arg = 8'hFF;
                    default: arg = 8'($urandom_range(0, 255));
                endcase
                if (arg == END_BYTE)
                    arg = 8'h0B;
                if (zero_args)
                    arg = 8'h00;
                seq.push_back(arg);
            end
        end
        else
        begin
            // noise: raw bytes, newlines inside make short or empty messages
            n_args = $urandom_range(0, 8);
            for (int i = 0; i < n_args; i++)
                seq.push_back(8'($urandom_range(0, 255)));
        end
        seq.push_back(END_BYTE);
        send_bytes(seq);
    endtask

    task automatic test_random_traffic(input int n_items);
        int start;
        start = items_sent;
        while (items_sent - start < n_items)
            send_random_message();
    endtask

    task automatic finish_run();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_status_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    endtask

    initial
    begin
        reset_lamp_model();
        send_idle_pct = 7;
        recv_idle_pct = 71;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        test_empty_message();
        test_color();
        test_long_interval();
        test_flags();
        test_random_traffic(PHASE_ITEMS);

        send_idle_pct = 71;
        recv_idle_pct = 7;
        test_random_traffic(PHASE_ITEMS);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(PHASE_ITEMS);

        finish_run();
    end

endmodule
